FILE: rtl/core/gdp_pkg.sv
package gdp_pkg;

  localparam int NUM_COEFS = 17;
  localparam int Q_FRAC = 16;
  localparam int H_SHIFT = 12;
  localparam int DIV_STAGES = 48;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_MAP = 1'b1;

  localparam int IDX_H0 = 0;
  localparam int IDX_H1 = 1;
  localparam int IDX_H2 = 2;
  localparam int IDX_H3 = 3;
  localparam int IDX_H4 = 4;
  localparam int IDX_H5 = 5;
  localparam int IDX_H6 = 6;
  localparam int IDX_H7 = 7;
  localparam int IDX_H8 = 8;
  localparam int IDX_FX = 9;
  localparam int IDX_FY = 10;
  localparam int IDX_CX = 11;
  localparam int IDX_CY = 12;
  localparam int IDX_K1 = 13;
  localparam int IDX_K2 = 14;
  localparam int IDX_K3 = 15;
  localparam int IDX_K4 = 16;

  localparam logic signed [15:0] X_MIN = 16'sd0;
  localparam logic signed [15:0] X_MAX = 16'sd16384;
  localparam logic signed [15:0] Y_MIN = -16'sd12288;
  localparam logic signed [15:0] Y_MAX = 16'sd12288;

  localparam logic signed [31:0] Q_ONE = 32'sd65536;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [65:0] L_MAX = 66'sd2147483647;
  localparam logic signed [65:0] L_MIN = -66'sd2147483648;
  localparam logic signed [65:0] P_MAX = 66'sd32767;
  localparam logic signed [65:0] P_MIN = -66'sd32768;
  localparam logic signed [65:0] P_ROUND = 66'sd65535;
  localparam logic signed [15:0] PIX_MAX = 16'sh7FFF;
  localparam logic signed [15:0] PIX_MIN = 16'sh8000;

  typedef struct packed {
    logic bad;
    logic signed [31:0] val;
  } sat_t;

  typedef struct packed {
    logic bad;
    logic signed [15:0] val;
  } pix_t;

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t r;
    if (v > L_MAX) begin
      r.bad = 1'b1;
      r.val = S32_MAX;
    end else if (v < L_MIN) begin
      r.bad = 1'b1;
      r.val = S32_MIN;
    end else begin
      r.bad = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  function automatic sat_t add_s(input logic signed [31:0] a, input logic signed [31:0] b);
    return sat32(66'(a) + 66'(b));
  endfunction

  function automatic sat_t sub_s(input logic signed [31:0] a, input logic signed [31:0] b);
    return sat32(66'(a) - 66'(b));
  endfunction

  function automatic sat_t qmul_s(input logic signed [63:0] p);
    return sat32(66'(p >>> Q_FRAC));
  endfunction

  function automatic sat_t dbl_s(input logic signed [31:0] a);
    return sat32(66'(a) <<< 1);
  endfunction

  function automatic sat_t homog_row(input logic signed [47:0] a, input logic signed [47:0] b,
                                     input logic signed [31:0] c);
    logic signed [65:0] sum;
    sum = 66'(a) + 66'(b) + (66'(c) <<< H_SHIFT);
    return sat32(sum >>> H_SHIFT);
  endfunction

  function automatic pix_t to_pix(input logic signed [63:0] f, input logic signed [31:0] c);
    logic signed [65:0] q;
    logic signed [65:0] t;
    logic signed [65:0] p;
    pix_t r;
    q = 66'(f >>> Q_FRAC) + 66'(c);
    t = (q < 66'sd0) ? q + P_ROUND : q;
    p = t >>> Q_FRAC;
    if (p > P_MAX) begin
      r.bad = 1'b1;
      r.val = PIX_MAX;
    end else if (p < P_MIN) begin
      r.bad = 1'b1;
      r.val = PIX_MIN;
    end else begin
      r.bad = 1'b0;
      r.val = p[15:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/gdp_ifs.sv
interface gdp_cmd_if;
  logic valid;
  logic ready;
  logic func;
  logic [4:0] coef_index;
  logic signed [31:0] coef_value;
  logic signed [15:0] world_x;
  logic signed [15:0] world_y;

  modport source (output valid, func, coef_index, coef_value, world_x, world_y, input ready);
  modport sink (input valid, func, coef_index, coef_value, world_x, world_y, output ready);
endinterface

interface gdp_pix_if;
  logic valid;
  logic ready;
  logic in_range;
  logic signed [15:0] pixel_x;
  logic signed [15:0] pixel_y;

  modport source (output valid, in_range, pixel_x, pixel_y, input ready);
  modport sink (input valid, in_range, pixel_x, pixel_y, output ready);
endinterface

FILE: rtl/core/gdp_div.sv
module gdp_div #(
  parameter int SIDE_W = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [31:0]  num [2],
  input  logic signed [31:0]  den [2],
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_valid,
  output logic signed [31:0]  quo [2],
  output logic                bad,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int NS = gdp_pkg::DIV_STAGES;
  localparam logic [NS-1:0] LIM = {{(NS-32){1'b0}}, 32'h8000_0000};

  logic              vld [NS];
  logic [SIDE_W-1:0] side [NS];
  logic [31:0]       rem [2][NS];
  logic [NS-1:0]     w [2][NS];
  logic [31:0]       dv [2][NS];
  logic              neg [2][NS];
  logic              dz [2][NS];
  logic              nneg [2][NS];

  logic [31:0]       rem_next [2][NS];
  logic [NS-1:0]     w_next [2][NS];
  logic [31:0]       dv_p [2][NS];
  logic              neg_p [2][NS];
  logic              dz_p [2][NS];
  logic              nneg_p [2][NS];
  logic              vld_p [NS];
  logic [SIDE_W-1:0] side_p [NS];
  logic [1:0]        lane_bad;

  for (genvar s = 0; s < NS; s++) begin : g_vs
    if (s == 0) begin : g_first
      assign vld_p[s] = in_valid;
      assign side_p[s] = side_in;
    end else begin : g_next
      assign vld_p[s] = vld[s-1];
      assign side_p[s] = side[s-1];
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [31:0] n_mag;
    logic [31:0] d_mag;
    logic [NS-1:0] mag;

    assign n_mag = num[l][31] ? 32'(-num[l]) : 32'(num[l]);
    assign d_mag = den[l][31] ? 32'(-den[l]) : 32'(den[l]);

    for (genvar s = 0; s < NS; s++) begin : g_st
      logic [31:0] rem_p;
      logic [NS-1:0] w_p;
      logic [32:0] cat;
      logic ok;

      if (s == 0) begin : g_first
        assign rem_p = '0;
        assign w_p = {n_mag, {gdp_pkg::Q_FRAC{1'b0}}};
        assign dv_p[l][s] = d_mag;
        assign neg_p[l][s] = num[l][31] ^ den[l][31];
        assign dz_p[l][s] = (den[l] == 32'sd0);
        assign nneg_p[l][s] = num[l][31];
      end else begin : g_next
        assign rem_p = rem[l][s-1];
        assign w_p = w[l][s-1];
        assign dv_p[l][s] = dv[l][s-1];
        assign neg_p[l][s] = neg[l][s-1];
        assign dz_p[l][s] = dz[l][s-1];
        assign nneg_p[l][s] = nneg[l][s-1];
      end

      assign cat = {rem_p, w_p[NS-1]};
      assign ok = (cat >= {1'b0, dv_p[l][s]});
      assign rem_next[l][s] = ok ? 32'(cat - {1'b0, dv_p[l][s]}) : cat[31:0];
      assign w_next[l][s] = {w_p[NS-2:0], ok};
    end

    assign mag = w[l][NS-1];

    always_comb begin
      if (dz[l][NS-1]) begin
        lane_bad[l] = 1'b1;
        quo[l] = nneg[l][NS-1] ? gdp_pkg::S32_MIN : gdp_pkg::S32_MAX;
      end else if (neg[l][NS-1]) begin
        lane_bad[l] = (mag > LIM);
        quo[l] = (mag > LIM) ? gdp_pkg::S32_MIN : 32'(-mag[31:0]);
      end else begin
        lane_bad[l] = (mag >= LIM);
        quo[l] = (mag >= LIM) ? gdp_pkg::S32_MAX : mag[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NS; s++) begin
        vld[s] <= 1'b0;
      end
    end else if (en) begin
      for (int s = 0; s < NS; s++) begin
        vld[s] <= vld_p[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        side[s] <= side_p[s];
        for (int l = 0; l < 2; l++) begin
          rem[l][s] <= rem_next[l][s];
          w[l][s] <= w_next[l][s];
          dv[l][s] <= dv_p[l][s];
          neg[l][s] <= neg_p[l][s];
          dz[l][s] <= dz_p[l][s];
          nneg[l][s] <= nneg_p[l][s];
        end
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign side_out = side[NS-1];
  assign bad = |lane_bad;

endmodule

FILE: rtl/core/ground_to_pixel_projection.sv
// ground plane to camera pixel projection
// cmd channel (sink): a word with func = load writes one calibration
//   coefficient (slot 0-8 homography, 9-12 fx fy cx cy, 13-16 k1-k4);
//   a word with func = map carries a ground point in q4.12
// result channel (source): one word per map word, in order, with
//   in_range and the distorted, saturated pixel; loads give no word
// throughput: one map word per cycle while the receiver does not stall;
//   a load word waits until no map word is left inside the arithmetic
//   pipeline; a map word passes two 48-stage radix-2 dividers (homography
//   divide, focal normalize) plus twelve multiply and add stages and the
//   output register
// a stalled receiver freezes the whole pipeline; the result word holds
//   and cmd ready drops for map words, nothing is dropped or repeated
// reset clears all valid bits and the in-flight count; coefficients
//   are not cleared and must be loaded before the first map word
module ground_to_pixel_projection #(
  parameter int COEF_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  gdp_cmd_if.sink         cmd,
  gdp_pix_if.source       result
);

  localparam int CS = (COEF_WIDTH < 32) ? COEF_WIDTH : 32;
  localparam int PIPE_DEPTH = 12 + 2 * gdp_pkg::DIV_STAGES;
  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  logic signed [CS-1:0] coef [gdp_pkg::NUM_COEFS];
  logic signed [31:0]   k [gdp_pkg::NUM_COEFS];

  logic adv;
  logic map_acc;
  logic load_acc;
  logic [CNT_W-1:0] cnt;

  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12;
  logic oob_in;
  logic oob1, oob2, oob3, oob4, oob5, oob6, oob7, oob8, oob9, oob10, oob11, oob12;
  logic bad2, bad3, bad4, bad5, bad6, bad7, bad8, bad9, bad10, bad11, bad12;

  logic signed [47:0] pxa, pxb, pya, pyb, pwa, pwb;
  logic signed [31:0] hx2, hy2, hw2;
  logic signed [31:0] num3x, num3y;
  logic signed [31:0] nx4, ny4, nx5, ny5, nx6, ny6, nx7, ny7, nx8, ny8;
  logic signed [63:0] pxx4, pyy4, pxy4;
  logic signed [31:0] xx5, yy5, cr5, rsq5;
  logic signed [63:0] m1_6, m2_6, m3_6, m4_6;
  logic signed [31:0] sx6, sy6;
  logic signed [31:0] rad1_7, m3q7, m4q7;
  logic signed [63:0] m5_7, m6_7, m7_7;
  logic signed [31:0] rad8, tanx8, tany8;
  logic signed [63:0] mx9, my9;
  logic signed [31:0] tanx9, tany9;
  logic signed [31:0] ex10, ey10;
  logic signed [63:0] fx11, fy11;
  logic signed [15:0] col12, row12;

  gdp_pkg::sat_t hx_s, hy_s, hw_s;
  gdp_pkg::sat_t sx3_s, sy3_s;
  gdp_pkg::sat_t xx_s, yy_s, cr_s, rsq_s;
  gdp_pkg::sat_t k3x2_s, k4x2_s, sx6_s, sy6_s;
  gdp_pkg::sat_t a1_s, rad1_s, m2q_s, m3q_s, m4q_s;
  gdp_pkg::sat_t m5q_s, m6q_s, m7q_s, rad_s, tanx_s, tany_s;
  gdp_pkg::sat_t mxq_s, myq_s, ex_s, ey_s;
  gdp_pkg::pix_t col_s, row_s;

  logic               d1_v, d1_bad, d2_v, d2_bad;
  logic signed [31:0] d1_num [2], d1_den [2], d1_q [2];
  logic signed [31:0] d2_num [2], d2_den [2], d2_q [2];
  logic [1:0]         d1_side, d2_side;

  for (genvar i = 0; i < gdp_pkg::NUM_COEFS; i++) begin : g_k
    assign k[i] = 32'(coef[i]);
  end

  assign adv = !result.valid || result.ready;

  always_comb begin
    if (cmd.func == gdp_pkg::FUNC_MAP) begin
      cmd.ready = adv;
    end else begin
      cmd.ready = (cnt == '0);
    end
  end

  assign map_acc = cmd.valid && cmd.ready && (cmd.func == gdp_pkg::FUNC_MAP);
  assign load_acc = cmd.valid && cmd.ready && (cmd.func == gdp_pkg::FUNC_LOAD);

  always_ff @(posedge clk) begin
    if (load_acc && (cmd.coef_index < 5'(gdp_pkg::NUM_COEFS))) begin
      coef[cmd.coef_index] <= cmd.coef_value[CS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + CNT_W'(map_acc) - CNT_W'(v12 && adv);
    end
  end

  assign oob_in = (cmd.world_x < gdp_pkg::X_MIN) || (cmd.world_x > gdp_pkg::X_MAX) ||
                  (cmd.world_y < gdp_pkg::Y_MIN) || (cmd.world_y > gdp_pkg::Y_MAX);

  // homography rows
  assign hx_s = gdp_pkg::homog_row(pxa, pxb, k[gdp_pkg::IDX_H2]);
  assign hy_s = gdp_pkg::homog_row(pya, pyb, k[gdp_pkg::IDX_H5]);
  assign hw_s = gdp_pkg::homog_row(pwa, pwb, k[gdp_pkg::IDX_H8]);

  assign d1_num[0] = hx2;
  assign d1_num[1] = hy2;
  assign d1_den[0] = hw2;
  assign d1_den[1] = hw2;

  gdp_div #(.SIDE_W(2)) u_div_h (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v2),
    .num(d1_num), .den(d1_den), .side_in({oob2, bad2}),
    .out_valid(d1_v), .quo(d1_q), .bad(d1_bad), .side_out(d1_side)
  );

  assign sx3_s = gdp_pkg::sub_s(d1_q[0], k[gdp_pkg::IDX_CX]);
  assign sy3_s = gdp_pkg::sub_s(d1_q[1], k[gdp_pkg::IDX_CY]);

  assign d2_num[0] = num3x;
  assign d2_num[1] = num3y;
  assign d2_den[0] = k[gdp_pkg::IDX_FX];
  assign d2_den[1] = k[gdp_pkg::IDX_FY];

  gdp_div #(.SIDE_W(2)) u_div_n (
    .clk(clk), .rst(rst), .en(adv), .in_valid(v3),
    .num(d2_num), .den(d2_den), .side_in({oob3, bad3}),
    .out_valid(d2_v), .quo(d2_q), .bad(d2_bad), .side_out(d2_side)
  );

  // distortion terms
  assign xx_s = gdp_pkg::qmul_s(pxx4);
  assign yy_s = gdp_pkg::qmul_s(pyy4);
  assign cr_s = gdp_pkg::qmul_s(pxy4);
  assign rsq_s = gdp_pkg::add_s(xx_s.val, yy_s.val);

  assign k3x2_s = gdp_pkg::dbl_s(k[gdp_pkg::IDX_K3]);
  assign k4x2_s = gdp_pkg::dbl_s(k[gdp_pkg::IDX_K4]);
  assign sx6_s = gdp_pkg::add_s(rsq5, xx5);
  assign sy6_s = gdp_pkg::add_s(rsq5, yy5);

  assign a1_s = gdp_pkg::qmul_s(m1_6);
  assign rad1_s = gdp_pkg::add_s(gdp_pkg::Q_ONE, a1_s.val);
  assign m2q_s = gdp_pkg::qmul_s(m2_6);
  assign m3q_s = gdp_pkg::qmul_s(m3_6);
  assign m4q_s = gdp_pkg::qmul_s(m4_6);

  assign m5q_s = gdp_pkg::qmul_s(m5_7);
  assign m6q_s = gdp_pkg::qmul_s(m6_7);
  assign m7q_s = gdp_pkg::qmul_s(m7_7);
  assign rad_s = gdp_pkg::add_s(rad1_7, m5q_s.val);
  assign tanx_s = gdp_pkg::add_s(m3q7, m6q_s.val);
  assign tany_s = gdp_pkg::add_s(m7q_s.val, m4q7);

  assign mxq_s = gdp_pkg::qmul_s(mx9);
  assign myq_s = gdp_pkg::qmul_s(my9);
  assign ex_s = gdp_pkg::add_s(mxq_s.val, tanx9);
  assign ey_s = gdp_pkg::add_s(myq_s.val, tany9);

  assign col_s = gdp_pkg::to_pix(fx11, k[gdp_pkg::IDX_CX]);
  assign row_s = gdp_pkg::to_pix(fy11, k[gdp_pkg::IDX_CY]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
      v10 <= 1'b0;
      v11 <= 1'b0;
      v12 <= 1'b0;
      result.valid <= 1'b0;
    end else if (adv) begin
      v1 <= map_acc;
      v2 <= v1;
      v3 <= d1_v;
      v4 <= d2_v;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
      v9 <= v8;
      v10 <= v9;
      v11 <= v10;
      v12 <= v11;
      result.valid <= v12;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oob1 <= oob_in;
      pxa <= 48'(cmd.world_x) * 48'(k[gdp_pkg::IDX_H0]);
      pxb <= 48'(cmd.world_y) * 48'(k[gdp_pkg::IDX_H1]);
      pya <= 48'(cmd.world_x) * 48'(k[gdp_pkg::IDX_H3]);
      pyb <= 48'(cmd.world_y) * 48'(k[gdp_pkg::IDX_H4]);
      pwa <= 48'(cmd.world_x) * 48'(k[gdp_pkg::IDX_H6]);
      pwb <= 48'(cmd.world_y) * 48'(k[gdp_pkg::IDX_H7]);

      oob2 <= oob1;
      bad2 <= hx_s.bad || hy_s.bad || hw_s.bad;
      hx2 <= hx_s.val;
      hy2 <= hy_s.val;
      hw2 <= hw_s.val;

      oob3 <= d1_side[1];
      bad3 <= d1_side[0] || d1_bad || sx3_s.bad || sy3_s.bad;
      num3x <= sx3_s.val;
      num3y <= sy3_s.val;

      oob4 <= d2_side[1];
      bad4 <= d2_side[0] || d2_bad;
      nx4 <= d2_q[0];
      ny4 <= d2_q[1];
      pxx4 <= 64'(d2_q[0]) * 64'(d2_q[0]);
      pyy4 <= 64'(d2_q[1]) * 64'(d2_q[1]);
      pxy4 <= 64'(d2_q[0]) * 64'(d2_q[1]);

      oob5 <= oob4;
      bad5 <= bad4 || xx_s.bad || yy_s.bad || cr_s.bad || rsq_s.bad;
      nx5 <= nx4;
      ny5 <= ny4;
      xx5 <= xx_s.val;
      yy5 <= yy_s.val;
      cr5 <= cr_s.val;
      rsq5 <= rsq_s.val;

      oob6 <= oob5;
      bad6 <= bad5 || k3x2_s.bad || k4x2_s.bad || sx6_s.bad || sy6_s.bad;
      nx6 <= nx5;
      ny6 <= ny5;
      m1_6 <= 64'(k[gdp_pkg::IDX_K1]) * 64'(rsq5);
      m2_6 <= 64'(rsq5) * 64'(rsq5);
      m3_6 <= 64'(k3x2_s.val) * 64'(cr5);
      m4_6 <= 64'(k4x2_s.val) * 64'(cr5);
      sx6 <= sx6_s.val;
      sy6 <= sy6_s.val;

      oob7 <= oob6;
      bad7 <= bad6 || a1_s.bad || rad1_s.bad || m2q_s.bad || m3q_s.bad || m4q_s.bad;
      nx7 <= nx6;
      ny7 <= ny6;
      rad1_7 <= rad1_s.val;
      m5_7 <= 64'(k[gdp_pkg::IDX_K2]) * 64'(m2q_s.val);
      m6_7 <= 64'(k[gdp_pkg::IDX_K4]) * 64'(sx6);
      m7_7 <= 64'(k[gdp_pkg::IDX_K3]) * 64'(sy6);
      m3q7 <= m3q_s.val;
      m4q7 <= m4q_s.val;

      oob8 <= oob7;
      bad8 <= bad7 || m5q_s.bad || m6q_s.bad || m7q_s.bad || rad_s.bad || tanx_s.bad ||
              tany_s.bad;
      nx8 <= nx7;
      ny8 <= ny7;
      rad8 <= rad_s.val;
      tanx8 <= tanx_s.val;
      tany8 <= tany_s.val;

      oob9 <= oob8;
      bad9 <= bad8;
      mx9 <= 64'(rad8) * 64'(nx8);
      my9 <= 64'(rad8) * 64'(ny8);
      tanx9 <= tanx8;
      tany9 <= tany8;

      oob10 <= oob9;
      bad10 <= bad9 || mxq_s.bad || myq_s.bad || ex_s.bad || ey_s.bad;
      ex10 <= ex_s.val;
      ey10 <= ey_s.val;

      oob11 <= oob10;
      bad11 <= bad10;
      fx11 <= 64'(k[gdp_pkg::IDX_FX]) * 64'(ex10);
      fy11 <= 64'(k[gdp_pkg::IDX_FY]) * 64'(ey10);

      oob12 <= oob11;
      bad12 <= bad11 || col_s.bad || row_s.bad;
      col12 <= col_s.val;
      row12 <= row_s.val;

      result.in_range <= !(oob12 || bad12);
      result.pixel_x <= oob12 ? 16'sd0 : col12;
      result.pixel_y <= oob12 ? 16'sd0 : row12;
    end
  end

endmodule
